FILE: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// Sector cache clock controller package
// Sizes, field widths and sequencer states shared by the controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  localparam int ENTRIES     = 64;
  localparam int SECTOR_BITS = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int OUT_W       = 1 + IDX_W + 1 + SECTOR_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_VICTIM,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/sector_cache_clock_controller_top.sv
// ----------------------------------------------------------------------------
// Sector cache clock controller
// Flow: an accepted item goes through the tag scan and then ST_FINISH on a hit or
// a free-slot fill; a miss on a full cache adds the clock sweep plus one victim
// tag read before ST_FINISH.
// Throughput: one item at a time; the next can be taken in the cycle after the
// result is loaded.
// Reset: rst synchronous, clears fill count, hand, accessed and dirty bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_clock_controller_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [scc_pkg::SECTOR_BITS-1:0]     s_tdata,  // sector
  input  wire logic                                s_tuser,  // operation
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // hit, slot, writeback_needed, victim_sector
  output logic [scc_pkg::OUT_TDATA_W-1:0]          m_tdata
);

  scc_pkg::state_t state, state_next;

  logic [scc_pkg::SECTOR_BITS-1:0] mem [scc_pkg::ENTRIES];
  logic [scc_pkg::SECTOR_BITS-1:0] rdata;
  logic [scc_pkg::IDX_W-1:0]       rd_addr;

  logic [scc_pkg::ENTRIES-1:0]     acc;
  logic [scc_pkg::ENTRIES-1:0]     dirty;

  logic                            op;
  logic [scc_pkg::SECTOR_BITS-1:0] sector;

  logic [scc_pkg::CNT_W-1:0]       idx, idx_next;
  logic [scc_pkg::CNT_W-1:0]       fill, fill_next;
  logic [scc_pkg::IDX_W-1:0]       hand, hand_next;
  logic [scc_pkg::IDX_W-1:0]       cmp_idx, cmp_idx_next;
  logic                            cmp_vld, cmp_vld_next;
  logic [scc_pkg::IDX_W-1:0]       slot, slot_next;
  logic                            hit, hit_next;
  logic                            wb, wb_next;
  logic [scc_pkg::SECTOR_BITS-1:0] victim, victim_next;

  logic                            accept;
  logic                            clr_acc;
  logic                            tag_we;
  logic                            out_load;
  logic [scc_pkg::IDX_W-1:0]       hand_inc;

  assign s_tready = (state == scc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign hand_inc = (hand == scc_pkg::IDX_W'(scc_pkg::ENTRIES - 1)) ?
                    '0 : hand + 1'b1;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    fill_next    = fill;
    hand_next    = hand;
    cmp_idx_next = cmp_idx;
    cmp_vld_next = 1'b0;
    slot_next    = slot;
    hit_next     = hit;
    wb_next      = wb;
    victim_next  = victim;
    rd_addr      = idx[scc_pkg::IDX_W-1:0];
    clr_acc      = 1'b0;
    tag_we       = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      scc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          idx_next    = '0;
          hit_next    = 1'b0;
          wb_next     = 1'b0;
          victim_next = '0;
          state_next  = scc_pkg::ST_SCAN;
        end
      end
      scc_pkg::ST_SCAN: begin
        priority if (cmp_vld && rdata == sector) begin
          hit_next   = 1'b1;
          slot_next  = cmp_idx;
          state_next = scc_pkg::ST_FINISH;
        end else if (idx < fill) begin
          rd_addr      = idx[scc_pkg::IDX_W-1:0];
          cmp_vld_next = 1'b1;
          cmp_idx_next = idx[scc_pkg::IDX_W-1:0];
          idx_next     = idx + 1'b1;
        end else if (fill < scc_pkg::CNT_W'(scc_pkg::ENTRIES)) begin
          slot_next  = fill[scc_pkg::IDX_W-1:0];
          fill_next  = fill + 1'b1;
          state_next = scc_pkg::ST_FINISH;
        end else begin
          state_next = scc_pkg::ST_SWEEP;
        end
      end
      scc_pkg::ST_SWEEP: begin
        rd_addr   = hand;
        hand_next = hand_inc;
        if (acc[hand]) begin
          clr_acc = 1'b1;
        end else begin
          slot_next  = hand;
          wb_next    = dirty[hand];
          state_next = scc_pkg::ST_VICTIM;
        end
      end
      scc_pkg::ST_VICTIM: begin
        victim_next = wb ? rdata : '0;
        state_next  = scc_pkg::ST_FINISH;
      end
      scc_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          tag_we     = !hit;
          state_next = scc_pkg::ST_IDLE;
        end
      end
      default: state_next = scc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= scc_pkg::ST_IDLE;
      idx     <= '0;
      fill    <= '0;
      hand    <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      fill    <= fill_next;
      hand    <= hand_next;
      cmp_vld <= cmp_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cmp_idx_next;
    slot    <= slot_next;
    hit     <= hit_next;
    wb      <= wb_next;
    victim  <= victim_next;
    if (accept) begin
      op     <= s_tuser;
      sector <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      mem[slot] <= sector;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      dirty <= '0;
    end else begin
      if (clr_acc) begin
        acc[hand] <= 1'b0;
      end
      if (out_load) begin
        acc[slot]   <= 1'b1;
        dirty[slot] <= op || (hit && dirty[slot]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= scc_pkg::OUT_TDATA_W'({victim, wb, slot, hit});
    end
  end

endmodule

`default_nettype wire

FILE: rtl/scc_checker.sv
// ----------------------------------------------------------------------------
// Sector cache clock controller checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [scc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int WB_BIT = 1 + scc_pkg::IDX_W;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("controller ready right after taking an item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[WB_BIT] |->
      m_tdata[WB_BIT+scc_pkg::SECTOR_BITS:WB_BIT+1] == '0)
    else $error("victim sector set without write-back");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[WB_BIT])
    else $error("write-back reported on a hit");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item valid after reset");

endmodule

bind sector_cache_clock_controller_top scc_checker u_scc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: dv/tb_sector_cache_clock_controller_top.sv
// ----------------------------------------------------------------------------
// Sector cache clock controller testbench
// Drives read and write accesses into the controller and checks each result
// against the table for typed rows, else a behavioural model of the cache:
// lookup, free-slot fill, clock sweep with second chance, dirty tracking and
// write-back reporting. Directed table accesses run first, then random ones
// mostly from a reused sector pool, with three idle patterns on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sector_cache_clock_controller_top;

  localparam logic OP_READ       = 1'b0;
  localparam logic OP_WRITE      = 1'b1;
  localparam int   DIR_N         = 25;
  localparam int   RAND_N        = 400;
  localparam int   POOL_N        = 96;
  localparam int   WATCHDOG_MAX  = 5000;
  localparam int   DRAIN_CYCLES  = 3 * scc_pkg::ENTRIES + 100;
  localparam int   REPORT_MAX    = 50;

  typedef struct packed {
    logic                            hit;
    logic [scc_pkg::IDX_W-1:0]       slot;
    logic                            wb;
    logic [31:0]                     victim;
  } cache_result_t;

  typedef struct packed {
    logic                            op;
    logic [scc_pkg::SECTOR_BITS-1:0] sector;
    logic                            typed;
    cache_result_t                   want;
  } access_row_t;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [scc_pkg::SECTOR_BITS-1:0] s_tdata  = '0;
  logic                            s_tuser  = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [scc_pkg::OUT_TDATA_W-1:0] m_tdata;

  // cache model state
  logic [scc_pkg::SECTOR_BITS-1:0] tag_mem   [scc_pkg::ENTRIES];
  logic                            acc_bit   [scc_pkg::ENTRIES];
  logic                            dirty_bit [scc_pkg::ENTRIES];
  int                              valid_cnt;
  int                              hand;

  cache_result_t                   pending_results [$];
  logic [scc_pkg::SECTOR_BITS-1:0] sector_pool [POOL_N];
  int                              mismatches  = 0;
  int                              results_seen = 0;
  int                              hits = 0, fills = 0, evictions = 0, writebacks = 0;
  int                              send_idle_pct = 21;
  int                              recv_idle_pct = 71;
  int                              quiet_cycles = 0;

  access_row_t dir_rows [DIR_N] = '{
    '{OP_READ,  32'h0000_0000, 1'b1, '{1'b0, 6'd0, 1'b0, 32'h0}},
    '{OP_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 6'd1, 1'b0, 32'h0}},
    '{OP_READ,  32'h0000_0000, 1'b1, '{1'b1, 6'd0, 1'b0, 32'h0}},
    '{OP_WRITE, 32'h0000_0000, 1'b1, '{1'b1, 6'd0, 1'b0, 32'h0}},
    '{OP_READ,  32'hFFFF_FFFF, 1'b1, '{1'b1, 6'd1, 1'b0, 32'h0}},
    '{OP_WRITE, 32'h8000_0000, 1'b1, '{1'b0, 6'd2, 1'b0, 32'h0}},
    '{OP_WRITE, 32'h0000_0001, 1'b1, '{1'b0, 6'd3, 1'b0, 32'h0}},
    '{OP_READ,  32'h7FFF_FFFF, 1'b1, '{1'b0, 6'd4, 1'b0, 32'h0}},
    '{OP_READ,  32'h5555_5555, 1'b1, '{1'b0, 6'd5, 1'b0, 32'h0}},
    '{OP_WRITE, 32'hAAAA_AAAA, 1'b1, '{1'b0, 6'd6, 1'b0, 32'h0}},
    '{OP_READ,  32'h8000_0000, 1'b0, '0},
    '{OP_WRITE, 32'h7FFF_FFFF, 1'b0, '0},
    '{OP_READ,  32'h1234_5678, 1'b0, '0},
    '{OP_WRITE, 32'hFEDC_BA98, 1'b0, '0},
    '{OP_READ,  32'h0000_0001, 1'b0, '0},
    '{OP_WRITE, 32'h5555_5555, 1'b0, '0},
    '{OP_READ,  32'hAAAA_AAAA, 1'b0, '0},
    '{OP_WRITE, 32'h0000_FFFF, 1'b0, '0},
    '{OP_READ,  32'hFFFF_0000, 1'b0, '0},
    '{OP_WRITE, 32'h0000_0000, 1'b0, '0},
    '{OP_READ,  32'h1234_5678, 1'b0, '0},
    '{OP_WRITE, 32'h00FF_00FF, 1'b0, '0},
    '{OP_READ,  32'hFF00_FF00, 1'b0, '0},
    '{OP_READ,  32'h0000_0000, 1'b0, '0},
    '{OP_WRITE, 32'hFFFF_FFFF, 1'b0, '0}
  };

  sector_cache_clock_controller_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic cache_result_t predict_access(logic op,
                                                   logic [scc_pkg::SECTOR_BITS-1:0] sec);
    cache_result_t r;
    int            idx;
    int            pos;
    r   = '0;
    idx = 0;
    for (int i = 0; i < valid_cnt; i++) begin
      if (tag_mem[i] == sec) begin
        r.hit = 1'b1;
        idx   = i;
        break;
      end
    end
    if (r.hit) begin
      hits++;
    end else begin
      if (valid_cnt < scc_pkg::ENTRIES) begin
        idx = valid_cnt;
        valid_cnt++;
        fills++;
      end else begin
        for (int g = 0; g < 2 * scc_pkg::ENTRIES + 1; g++) begin
          pos  = hand;
          hand = (hand + 1) % scc_pkg::ENTRIES;
          if (!acc_bit[pos]) begin
            idx = pos;
            break;
          end
          acc_bit[pos] = 1'b0;
        end
        evictions++;
        if (dirty_bit[idx]) begin
          r.wb     = 1'b1;
          r.victim = 32'(tag_mem[idx]);
          writebacks++;
        end
      end
      dirty_bit[idx] = 1'b0;
      tag_mem[idx]   = sec;
    end
    acc_bit[idx] = 1'b1;
    if (op == OP_WRITE) dirty_bit[idx] = 1'b1;
    r.slot = scc_pkg::IDX_W'(idx);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < REPORT_MAX)
      $display("mismatch: %s at result %0d, got %h, want %h", what, results_seen, got, want);
    mismatches++;
  endtask

  task automatic send_access(logic op, logic [scc_pkg::SECTOR_BITS-1:0] sec, logic typed,
                             cache_result_t want);
    cache_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= sec;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_access(op, sec);
    pending_results.push_back(typed ? want : r);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", m_tdata[31:0], 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.hit)
          report_mismatch("hit", 32'(m_tdata[0]), 32'(want.hit));
        if (m_tdata[scc_pkg::IDX_W:1] !== want.slot)
          report_mismatch("slot", 32'(m_tdata[scc_pkg::IDX_W:1]), 32'(want.slot));
        if (m_tdata[scc_pkg::IDX_W+1] !== want.wb)
          report_mismatch("writeback_needed", 32'(m_tdata[scc_pkg::IDX_W+1]),
                          32'(want.wb));
        if (m_tdata[scc_pkg::IDX_W+33:scc_pkg::IDX_W+2] !== want.victim)
          report_mismatch("victim_sector", m_tdata[scc_pkg::IDX_W+33:scc_pkg::IDX_W+2],
                          want.victim);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [scc_pkg::SECTOR_BITS-1:0] sec;
    int                              pick;
    for (int i = 0; i < scc_pkg::ENTRIES; i++) begin
      tag_mem[i]   = '0;
      acc_bit[i]   = 1'b0;
      dirty_bit[i] = 1'b0;
    end
    valid_cnt = 0;
    hand      = 0;
    for (int i = 0; i < POOL_N; i++) sector_pool[i] = $urandom;
    sector_pool[0] = '0;
    sector_pool[1] = '1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < DIR_N; n++)
      send_access(dir_rows[n].op, dir_rows[n].sector, dir_rows[n].typed, dir_rows[n].want);

    for (int n = 0; n < RAND_N; n++) begin
      if (n == RAND_N / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 21;
      end else if (n == 2 * RAND_N / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        sec = sector_pool[$urandom_range(POOL_N - 1)];
      end else if (pick < 95) begin
        sec = $urandom;
      end else begin
        sec = $urandom_range(1) ? '1 : '0;
      end
      send_access(logic'($urandom_range(1)), sec, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 32'h0);
    $display("covered %0d accesses: %0d hits, %0d free-slot fills, %0d evictions",
             DIR_N + RAND_N, hits, fills, evictions);
    $display("%0d dirty victims written back, %0d mismatches", writebacks, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/scc_pkg.sv
rtl/sector_cache_clock_controller_top.sv
rtl/scc_checker.sv
dv/tb_sector_cache_clock_controller_top.sv
